[hw/rtl/tdsac_pkg.sv]
// Shared widths, types and constants of the TDS averager and converter.
package tdsac_pkg;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Window length and ADC resolution.
   localparam int WINDOW_SAMPLES = 32;
   localparam int ADC_BITS       = 12;

   // Field widths.
   localparam int CODE_W = ADC_BITS;
   localparam int MV_W   = 13;
   localparam int REF_W  = 13;
   localparam int GAIN_W = 16;
   localparam int TDS_W  = 18;

   // Voltage is unsigned Q3.16; square and cube keep 16 fraction bits.
   localparam int FRAC_W = 16;
   localparam int VOLT_W = 19;
   localparam int V2_W   = 2 * VOLT_W - FRAC_W;
   localparam int V3_W   = V2_W + VOLT_W - FRAC_W;

   // Accumulators and sample counter.
   localparam int WIN_LOG = $clog2(WINDOW_SAMPLES);
   localparam int CNT_W   = (WIN_LOG > 0) ? WIN_LOG : 1;
   localparam int CSUM_W  = CODE_W + WIN_LOG;
   localparam int MSUM_W  = MV_W + WIN_LOG;

   // Voltage divisor: full scale code times 1000 mV per volt.
   localparam longint FULL_SCALE   = (64'd1 << ADC_BITS) - 64'd1;
   localparam longint VOLT_DIVISOR = FULL_SCALE * 64'd1000;
   localparam int     VDIV_W       = $clog2(VOLT_DIVISOR + 1);
   localparam int     WDIV_W       = $clog2(WINDOW_SAMPLES + 1);

   // Serial divider: dividend register and divisor width.
   localparam int NUM_W = CODE_W + REF_W + FRAC_W;
   localparam int DVD_W = imax(NUM_W, imax(CSUM_W, MSUM_W));
   localparam int DSR_W = imax(VDIV_W, WDIV_W);

   // Polynomial coefficients with 8 fraction bits: Q8.8 cube and square, Q10.8 linear.
   localparam int CUBE_COEF_W = 16;
   localparam int SQR_COEF_W  = 16;
   localparam int LIN_COEF_W  = 18;

   // Polynomial terms.
   localparam int CUBE_TERM_W = CUBE_COEF_W + V3_W;
   localparam int LIN_TERM_W  = LIN_COEF_W + VOLT_W;
   localparam int TERM_W      = imax(CUBE_TERM_W, LIN_TERM_W) + 1;

   // Gain times ten, then the shift that brings Q24 times Q4.12 back to tenths.
   localparam int G10_W     = GAIN_W + 4;
   localparam int OUT_SHIFT = 36;

   // Serial multiplier: the multiplicand is added, the multiplier is scanned a bit a cycle.
   // The widest multiplicand is the scaled gain, the widest multiplier the polynomial value.
   localparam int MCAND_W = imax(G10_W, imax(LIN_COEF_W, imax(VOLT_W, REF_W)));
   localparam int MLR_W   = imax(TERM_W, imax(V3_W, CODE_W));
   localparam int PROD_W  = MCAND_W + MLR_W;

   localparam int ITER_MAX = imax(DVD_W, MLR_W);
   localparam int STEP_W   = $clog2(ITER_MAX);

   // Stream payloads, padded to whole bytes.
   localparam int REQ_DATA_W = ((CODE_W + MV_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CODE_W + MV_W + TDS_W + 7) / 8) * 8;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   typedef logic [CODE_W-1:0]     code_type;
   typedef logic [MV_W-1:0]       mv_type;
   typedef logic [REF_W-1:0]      ref_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic [TDS_W-1:0]      tds_type;
   typedef logic [VOLT_W-1:0]     volt_type;
   typedef logic [V2_W-1:0]       v2_type;
   typedef logic [V3_W-1:0]       v3_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [CSUM_W-1:0]     csum_type;
   typedef logic [MSUM_W-1:0]     msum_type;
   typedef logic [DVD_W-1:0]      dvd_type;
   typedef logic [DSR_W-1:0]      dsr_type;
   typedef logic [TERM_W-1:0]     term_type;
   typedef logic [G10_W-1:0]      g10_type;
   typedef logic [MCAND_W-1:0]    mcand_type;
   typedef logic [MLR_W-1:0]      mlr_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [REG_IDX_W-1:0]  reg_idx_type;

   localparam logic [CUBE_COEF_W-1:0] COEF_CUBE   = 16'd34156;
   localparam logic [SQR_COEF_W-1:0]  COEF_SQUARE = 16'd65500;
   localparam logic [LIN_COEF_W-1:0]  COEF_LINEAR = 18'd219492;

   localparam volt_type VOLT_MAX = {VOLT_W{1'b1}};
   localparam tds_type  TDS_MAX  = {TDS_W{1'b1}};

   localparam dsr_type  WIN_DIVISOR  = dsr_type'(WINDOW_SAMPLES);
   localparam dsr_type  VOLT_DSR     = dsr_type'(VOLT_DIVISOR);
   localparam cnt_type  CNT_LAST     = cnt_type'(WINDOW_SAMPLES - 1);
   localparam step_type DIV_LAST     = step_type'(DVD_W - 1);
   localparam step_type MUL_LAST     = step_type'(MLR_W - 1);

   localparam reg_idx_type REG_REFERENCE = 1'b0;
   localparam reg_idx_type REG_GAIN      = 1'b1;

   localparam ref_type  RESET_REFERENCE = 13'd3300;
   localparam gain_type RESET_GAIN      = 16'd4096;

endpackage

[hw/rtl/tds_average_and_convert.sv]
// Top level of the TDS window averager and ppm converter.
//
// Paired samples (raw ADC code and millivolt reading) arrive on the req_ stream channel
// and are summed while the block is collecting; one transaction per cycle is taken then.
// The transaction that completes a window of WINDOW_SAMPLES samples starts the conversion:
// two window averages and the voltage come from a restoring divider that retires one
// quotient bit per cycle, and the product chain of the voltage numerator, the cubic and
// the gain runs on a shift-add multiplier that scans one multiplier bit per cycle. The
// result passes through the emit state into the output register that drives rsp_.
// req_tready is low while the conversion runs. A finished result sits in the output
// register until rsp_tready takes it; the block keeps collecting the next window
// meanwhile, and only a conversion that finishes while the old result is still waiting
// holds in its final state until the register frees. The registers on the csr_ port
// must be written only while the block is idle; the block itself does not enforce this.
// Reset (synchronous) discards partial sums, aborts any conversion, drops a waiting
// result and restores the register defaults.
module tds_average_and_convert (
   input  logic                     clock,
   input  logic                     reset,
   // Sample channel.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata from bit 0 up: raw_code, sample_millivolts, zero padding.
   input  tdsac_pkg::req_data_type  req_tdata,
   // Result channel.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata from bit 0 up: average_code, average_millivolts, dissolved_tenths_ppm, padding.
   output tdsac_pkg::rsp_data_type  rsp_tdata,
   // tuser: saturated.
   output logic                     rsp_tuser,
   // Register port.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  tdsac_pkg::csr_addr_type  csr_paddr,
   input  tdsac_pkg::csr_data_type  csr_pwdata,
   output tdsac_pkg::csr_data_type  csr_prdata,
   output logic                     csr_pready
);

   // Sequencer: collect samples, then walk through the divide and multiply steps.
   typedef enum logic [12:0] {
      ST_COLLECT    = 13'h0001,
      ST_DIV_CODE   = 13'h0002,
      ST_DIV_MV     = 13'h0004,
      ST_MUL_NUM    = 13'h0008,
      ST_DIV_VOLT   = 13'h0010,
      ST_MUL_SQ     = 13'h0020,
      ST_MUL_CUBE_V = 13'h0040,
      ST_MUL_CUBE   = 13'h0080,
      ST_MUL_LIN    = 13'h0100,
      ST_MUL_SQT    = 13'h0200,
      ST_MUL_GAIN   = 13'h0400,
      ST_EMIT       = 13'h0800,
      ST_SPARE      = 13'h1000
   } state_type;

   state_type state_ff, state_in;
   tdsac_pkg::step_type  step_ff, step_in;
   tdsac_pkg::cnt_type   count_ff, count_in;
   tdsac_pkg::csum_type  code_sum_ff, code_sum_in;
   tdsac_pkg::msum_type  mv_sum_ff, mv_sum_in;

   tdsac_pkg::ref_type   ref_ff, ref_in;
   tdsac_pkg::gain_type  gain_ff, gain_in;

   // Divider registers: partial remainder, dividend shifting out while quotient shifts in.
   tdsac_pkg::dsr_type   div_rem_ff, div_rem_in;
   tdsac_pkg::dvd_type   div_dq_ff, div_dq_in;
   tdsac_pkg::dsr_type   div_dsr_ff, div_dsr_in;

   // Multiplier registers: upper product half, multiplier sharing the lower half.
   tdsac_pkg::mcand_type mul_hi_ff, mul_hi_in;
   tdsac_pkg::mlr_type   mul_lo_ff, mul_lo_in;
   tdsac_pkg::mcand_type mul_mcand_ff, mul_mcand_in;

   // Intermediate results.
   tdsac_pkg::code_type  avg_code_ff, avg_code_in;
   tdsac_pkg::mv_type    avg_mv_ff, avg_mv_in;
   tdsac_pkg::volt_type  volt_ff, volt_in;
   tdsac_pkg::v2_type    v2_ff, v2_in;
   tdsac_pkg::v3_type    v3_ff, v3_in;
   tdsac_pkg::term_type  term_ff, term_in;
   tdsac_pkg::tds_type   tds_ff, tds_in;
   logic                 sat_ff, sat_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   tdsac_pkg::code_type  rsp_code_ff, rsp_code_in;
   tdsac_pkg::mv_type    rsp_mv_ff, rsp_mv_in;
   tdsac_pkg::tds_type   rsp_tds_ff, rsp_tds_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // Combinational step results.
   logic [tdsac_pkg::DSR_W+1:0]   div_diff;
   logic                          div_qbit;
   tdsac_pkg::dsr_type            div_rem_next;
   tdsac_pkg::dvd_type            div_quo;
   logic [tdsac_pkg::MCAND_W:0]   mul_sum;
   tdsac_pkg::prod_type           mul_prod;
   logic                          div_last, mul_last;
   logic                          req_take, rsp_free, csr_write;
   tdsac_pkg::code_type           req_code;
   tdsac_pkg::mv_type             req_mv;
   tdsac_pkg::csum_type           code_total;
   tdsac_pkg::msum_type           mv_total;
   tdsac_pkg::g10_type            gain10;
   tdsac_pkg::volt_type           volt_next;
   tdsac_pkg::v2_type             v2_next;
   tdsac_pkg::v3_type             v3_next;
   tdsac_pkg::term_type           prod_term;
   tdsac_pkg::reg_idx_type        csr_idx;

   // Load requests for the shared units, set by the sequencer.
   logic                          div_load, mul_load;
   tdsac_pkg::dvd_type            div_load_dvd;
   tdsac_pkg::dsr_type            div_load_dsr;
   tdsac_pkg::mcand_type          mul_load_mcand;
   tdsac_pkg::mlr_type            mul_load_mlr;

   assign req_code   = req_tdata[tdsac_pkg::CODE_W-1:0];
   assign req_mv     = req_tdata[tdsac_pkg::CODE_W +: tdsac_pkg::MV_W];
   assign req_tready = (state_ff == ST_COLLECT);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign code_total = code_sum_ff + tdsac_pkg::csum_type'(req_code);
   assign mv_total   = mv_sum_ff + tdsac_pkg::msum_type'(req_mv);

   // One restoring division step: bring down the next dividend bit and try a subtract.
   assign div_diff = {1'b0, div_rem_ff, div_dq_ff[tdsac_pkg::DVD_W-1]}
                     - {2'b00, div_dsr_ff};
   assign div_qbit = ~div_diff[tdsac_pkg::DSR_W+1];
   // When the subtract fails the shifted remainder is below the divisor, so its top bit is zero.
   assign div_rem_next = div_qbit ? div_diff[tdsac_pkg::DSR_W-1:0]
                                  : {div_rem_ff[tdsac_pkg::DSR_W-2:0],
                                     div_dq_ff[tdsac_pkg::DVD_W-1]};
   assign div_quo  = {div_dq_ff[tdsac_pkg::DVD_W-2:0], div_qbit};

   // One shift-add multiply step on the lowest multiplier bit, then shift the product right.
   assign mul_sum  = {1'b0, mul_hi_ff}
                     + (mul_lo_ff[0] ? {1'b0, mul_mcand_ff} : {(tdsac_pkg::MCAND_W+1){1'b0}});
   assign mul_prod = {mul_sum, mul_lo_ff[tdsac_pkg::MLR_W-1:1]};

   assign div_last = (step_ff == tdsac_pkg::DIV_LAST);
   assign mul_last = (step_ff == tdsac_pkg::MUL_LAST);

   // Gain times ten as two shifted copies.
   assign gain10 = tdsac_pkg::g10_type'({gain_ff, 3'b000})
                   + tdsac_pkg::g10_type'({gain_ff, 1'b0});

   // The voltage is held at the top of the Q3.16 range.
   assign volt_next = (|div_quo[tdsac_pkg::DVD_W-1:tdsac_pkg::VOLT_W])
                      ? tdsac_pkg::VOLT_MAX : div_quo[tdsac_pkg::VOLT_W-1:0];
   assign v2_next   = mul_prod[tdsac_pkg::FRAC_W +: tdsac_pkg::V2_W];
   assign v3_next   = mul_prod[tdsac_pkg::FRAC_W +: tdsac_pkg::V3_W];
   assign prod_term = mul_prod[tdsac_pkg::TERM_W-1:0];

   // Register writes land on the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[tdsac_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      unique case (csr_idx)
         tdsac_pkg::REG_REFERENCE: csr_prdata = tdsac_pkg::csr_data_type'(ref_ff);
         tdsac_pkg::REG_GAIN:      csr_prdata = tdsac_pkg::csr_data_type'(gain_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_comb begin
      ref_in  = ref_ff;
      gain_in = gain_ff;
      if (csr_write) begin
         unique case (csr_idx)
            tdsac_pkg::REG_REFERENCE: ref_in  = csr_pwdata[tdsac_pkg::REF_W-1:0];
            tdsac_pkg::REG_GAIN:      gain_in = csr_pwdata[tdsac_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer. Each divide or multiply state steps its unit; on the last step the result is
   // captured and, except after the gain multiply, a unit is loaded for the next operation.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      code_sum_in    = code_sum_ff;
      mv_sum_in      = mv_sum_ff;
      avg_code_in    = avg_code_ff;
      avg_mv_in      = avg_mv_ff;
      volt_in        = volt_ff;
      v2_in          = v2_ff;
      v3_in          = v3_ff;
      term_in        = term_ff;
      tds_in         = tds_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_code_in    = rsp_code_ff;
      rsp_mv_in      = rsp_mv_ff;
      rsp_tds_in     = rsp_tds_ff;
      rsp_sat_in     = rsp_sat_ff;
      div_load       = 1'b0;
      div_load_dvd   = '0;
      div_load_dsr   = '0;
      mul_load       = 1'b0;
      mul_load_mcand = '0;
      mul_load_mlr   = '0;
      step_in        = '0;

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_take) begin
               code_sum_in = code_total;
               mv_sum_in   = mv_total;
               if (count_ff == tdsac_pkg::CNT_LAST) begin
                  count_in     = '0;
                  div_load     = 1'b1;
                  div_load_dvd = tdsac_pkg::dvd_type'(code_total);
                  div_load_dsr = tdsac_pkg::WIN_DIVISOR;
                  state_in     = ST_DIV_CODE;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_DIV_CODE: begin
            step_in = step_ff + 1'b1;
            if (div_last) begin
               step_in      = '0;
               avg_code_in  = div_quo[tdsac_pkg::CODE_W-1:0];
               code_sum_in  = '0;
               div_load     = 1'b1;
               div_load_dvd = tdsac_pkg::dvd_type'(mv_sum_ff);
               div_load_dsr = tdsac_pkg::WIN_DIVISOR;
               state_in     = ST_DIV_MV;
            end
         end
         ST_DIV_MV: begin
            step_in = step_ff + 1'b1;
            if (div_last) begin
               step_in        = '0;
               avg_mv_in      = div_quo[tdsac_pkg::MV_W-1:0];
               mv_sum_in      = '0;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(ref_ff);
               mul_load_mlr   = tdsac_pkg::mlr_type'(avg_code_ff);
               state_in       = ST_MUL_NUM;
            end
         end
         ST_MUL_NUM: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               // Code times reference, scaled by 2^16, over full scale times 1000.
               step_in      = '0;
               div_load     = 1'b1;
               div_load_dvd = tdsac_pkg::dvd_type'(
                                 {mul_prod[tdsac_pkg::CODE_W+tdsac_pkg::REF_W-1:0],
                                  {tdsac_pkg::FRAC_W{1'b0}}});
               div_load_dsr = tdsac_pkg::VOLT_DSR;
               state_in     = ST_DIV_VOLT;
            end
         end
         ST_DIV_VOLT: begin
            step_in = step_ff + 1'b1;
            if (div_last) begin
               step_in        = '0;
               volt_in        = volt_next;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(volt_next);
               mul_load_mlr   = tdsac_pkg::mlr_type'(volt_next);
               state_in       = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               step_in        = '0;
               v2_in          = v2_next;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(volt_ff);
               mul_load_mlr   = tdsac_pkg::mlr_type'(v2_next);
               state_in       = ST_MUL_CUBE_V;
            end
         end
         ST_MUL_CUBE_V: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               step_in        = '0;
               v3_in          = v3_next;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(tdsac_pkg::COEF_CUBE);
               mul_load_mlr   = tdsac_pkg::mlr_type'(v3_next);
               state_in       = ST_MUL_CUBE;
            end
         end
         ST_MUL_CUBE: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               step_in        = '0;
               term_in        = prod_term;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(tdsac_pkg::COEF_LINEAR);
               mul_load_mlr   = tdsac_pkg::mlr_type'(volt_ff);
               state_in       = ST_MUL_LIN;
            end
         end
         ST_MUL_LIN: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               step_in        = '0;
               term_in        = term_ff + prod_term;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(tdsac_pkg::COEF_SQUARE);
               mul_load_mlr   = tdsac_pkg::mlr_type'(v2_ff);
               state_in       = ST_MUL_SQT;
            end
         end
         ST_MUL_SQT: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               // A negative cubic clamps to zero.
               step_in        = '0;
               term_in        = (term_ff >= prod_term) ? term_ff - prod_term : '0;
               mul_load       = 1'b1;
               mul_load_mcand = tdsac_pkg::mcand_type'(gain10);
               mul_load_mlr   = tdsac_pkg::mlr_type'(term_in);
               state_in       = ST_MUL_GAIN;
            end
         end
         ST_MUL_GAIN: begin
            step_in = step_ff + 1'b1;
            if (mul_last) begin
               step_in  = '0;
               sat_in   = |mul_prod[tdsac_pkg::PROD_W-1:tdsac_pkg::OUT_SHIFT+tdsac_pkg::TDS_W];
               tds_in   = sat_in ? tdsac_pkg::TDS_MAX
                                 : mul_prod[tdsac_pkg::OUT_SHIFT +: tdsac_pkg::TDS_W];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Wait here while an older result still occupies the output register.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = avg_code_ff;
               rsp_mv_in    = avg_mv_ff;
               rsp_tds_in   = tds_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Shared units step every cycle of their states and load on request.
   always_comb begin
      div_rem_in   = div_rem_ff;
      div_dq_in    = div_dq_ff;
      div_dsr_in   = div_dsr_ff;
      mul_hi_in    = mul_hi_ff;
      mul_lo_in    = mul_lo_ff;
      mul_mcand_in = mul_mcand_ff;
      if (state_ff == ST_DIV_CODE || state_ff == ST_DIV_MV || state_ff == ST_DIV_VOLT) begin
         div_rem_in = div_rem_next;
         div_dq_in  = div_quo;
      end
      if (div_load) begin
         div_rem_in = '0;
         div_dq_in  = div_load_dvd;
         div_dsr_in = div_load_dsr;
      end
      if (state_ff == ST_MUL_NUM || state_ff == ST_MUL_SQ || state_ff == ST_MUL_CUBE_V
          || state_ff == ST_MUL_CUBE || state_ff == ST_MUL_LIN || state_ff == ST_MUL_SQT
          || state_ff == ST_MUL_GAIN) begin
         mul_hi_in = mul_prod[tdsac_pkg::PROD_W-1:tdsac_pkg::MLR_W];
         mul_lo_in = mul_prod[tdsac_pkg::MLR_W-1:0];
      end
      if (mul_load) begin
         mul_hi_in    = '0;
         mul_lo_in    = mul_load_mlr;
         mul_mcand_in = mul_load_mcand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         step_ff      <= '0;
         count_ff     <= '0;
         code_sum_ff  <= '0;
         mv_sum_ff    <= '0;
         ref_ff       <= tdsac_pkg::RESET_REFERENCE;
         gain_ff      <= tdsac_pkg::RESET_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         code_sum_ff  <= code_sum_in;
         mv_sum_ff    <= mv_sum_in;
         ref_ff       <= ref_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff   <= div_rem_in;
      div_dq_ff    <= div_dq_in;
      div_dsr_ff   <= div_dsr_in;
      mul_hi_ff    <= mul_hi_in;
      mul_lo_ff    <= mul_lo_in;
      mul_mcand_ff <= mul_mcand_in;
      avg_code_ff  <= avg_code_in;
      avg_mv_ff    <= avg_mv_in;
      volt_ff      <= volt_in;
      v2_ff        <= v2_in;
      v3_ff        <= v3_in;
      term_ff      <= term_in;
      tds_ff       <= tds_in;
      sat_ff       <= sat_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_mv_ff    <= rsp_mv_in;
      rsp_tds_ff   <= rsp_tds_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tdsac_pkg::rsp_data_type'({rsp_tds_ff, rsp_mv_ff, rsp_code_ff});
   assign rsp_tuser  = rsp_sat_ff;

   // The sample that closes a window starts the conversion with a fresh step count.
   a_window_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && count_ff == tdsac_pkg::CNT_LAST)
      |=> (state_ff == ST_DIV_CODE && count_ff == '0 && step_ff == '0))
      else $error("window end did not start the conversion");

   // A result only appears from the final sequencer state.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result shown outside the emit state");

   // A finished conversion waits rather than overwriting an untaken result.
   a_result_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_EMIT))
      else $error("pending result overwritten");

   // The saturation flag always comes with the top of the output range.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_tds_ff == tdsac_pkg::TDS_MAX))
      else $error("saturated result not at full scale");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the TDS window averager and ppm converter.
`timescale 1ns / 1ps

module tb_top;

   // Limits of the sample fields and of the result.
   localparam int unsigned CODE_TOP = (1 << tdsac_pkg::CODE_W) - 1;
   localparam int unsigned MV_TOP   = (1 << tdsac_pkg::MV_W) - 1;
   localparam int          WINDOW   = tdsac_pkg::WINDOW_SAMPLES;

   // Positions of the result fields in rsp_tdata.
   localparam int CODE_BITS = tdsac_pkg::CODE_W;
   localparam int MV_BITS   = tdsac_pkg::MV_W;
   localparam int TDS_BITS  = tdsac_pkg::TDS_W;
   localparam int TDS_LSB   = CODE_BITS + MV_BITS;

   // Fixed-point constants of the conversion: cubic coefficients Q8.8, linear Q10.8,
   // the voltage is unsigned Q3.16 and clamps at the top of that range.
   localparam bit [63:0] FULL_SCALE_CODE = (64'd1 << tdsac_pkg::ADC_BITS) - 64'd1;
   localparam bit [63:0] CUBE_Q8         = 64'd34156;
   localparam bit [63:0] SQUARE_Q8       = 64'd65500;
   localparam bit [63:0] LINEAR_Q8       = 64'd219492;
   localparam bit [63:0] VOLT_CEILING    = 64'h7FFFF;
   localparam bit [63:0] TENTHS_CEILING  = 64'd262143;

   localparam int SETTLE_CYCLES    = 450;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int CYCLE_LIMIT      = 600000;

   typedef struct packed {
      tdsac_pkg::code_type code;
      tdsac_pkg::mv_type   mv;
      tdsac_pkg::tds_type  tds;
      logic                sat;
   } window_result_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   tdsac_pkg::req_data_type req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   tdsac_pkg::rsp_data_type rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   tdsac_pkg::csr_addr_type csr_paddr   = '0;
   tdsac_pkg::csr_data_type csr_pwdata  = '0;
   tdsac_pkg::csr_data_type csr_prdata;
   logic                    csr_pready;

   // Our own copy of the block's registers and window accumulators.
   tdsac_pkg::ref_type  model_reference   = tdsac_pkg::ref_type'(3300);
   tdsac_pkg::gain_type model_gain        = tdsac_pkg::gain_type'(4096);
   bit [63:0]           code_total        = '0;
   bit [63:0]           mv_total          = '0;
   int                  samples_in_window = 0;

   // Results still owed by the block, oldest first.
   window_result_type pending_windows[$];

   int mismatches    = 0;
   int cycles_run    = 0;
   int hold_requests = 0;
   bit req_gaps_on   = 1'b0;
   bit sink_stalls_on = 1'b0;

   always #5 clock = ~clock;

   tds_average_and_convert DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Logs a mismatch; only the first ten are printed, the rest are only counted.
   function automatic void report_mismatch(input string what, input longint unsigned want,
                                           input longint unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Converts a window's mean code to tenths of ppm. Every step truncates, the
   // voltage clamps at the top of Q3.16, a negative cubic gives zero with the flag
   // clear, and anything above the 18-bit range saturates with the flag set.
   function automatic tdsac_pkg::tds_type tenths_from_average(input tdsac_pkg::code_type avg,
                                                              output logic sat);
      bit [63:0] volts, square, cube, rising, falling, poly, tenths;
      volts = (64'(avg) * 64'(model_reference) * 64'd65536) / (FULL_SCALE_CODE * 64'd1000);
      if (volts > VOLT_CEILING) volts = VOLT_CEILING;
      square  = (volts * volts) >> 16;
      cube    = (square * volts) >> 16;
      rising  = CUBE_Q8 * cube + LINEAR_Q8 * volts;
      falling = SQUARE_Q8 * square;
      poly    = (falling > rising) ? 64'd0 : rising - falling;
      tenths  = (poly * 64'(model_gain) * 64'd10) >> 36;
      sat     = (tenths > TENTHS_CEILING);
      if (sat) tenths = TENTHS_CEILING;
      return tdsac_pkg::tds_type'(tenths);
   endfunction

   // Adds one accepted sample to the running window. The sample that closes the
   // window queues the result the block owes for it and clears the sums.
   function automatic void accumulate_sample(input tdsac_pkg::code_type code,
                                             input tdsac_pkg::mv_type mv);
      window_result_type res;
      logic sat;
      code_total += 64'(code);
      mv_total   += 64'(mv);
      samples_in_window++;
      if (samples_in_window == WINDOW) begin
         res.code = tdsac_pkg::code_type'(code_total / WINDOW);
         res.mv   = tdsac_pkg::mv_type'(mv_total / WINDOW);
         res.tds  = tenths_from_average(res.code, sat);
         res.sat  = sat;
         pending_windows.push_back(res);
         code_total        = '0;
         mv_total          = '0;
         samples_in_window = 0;
      end
   endfunction

   function automatic int unsigned pick_near(input int unsigned mid, input int unsigned reach,
                                             input int unsigned top);
      int unsigned lo, hi;
      lo = (mid > reach) ? mid - reach : 0;
      hi = (mid + reach > top) ? top : mid + reach;
      return $urandom_range(hi, lo);
   endfunction

   // Offers one sample and waits for its transaction. When sender idling is on, a
   // random burst of idle cycles may come first; valid is only lowered for such a
   // burst, so back-to-back samples keep it high without a glitch.
   task automatic send_sample(input tdsac_pkg::code_type code, input tdsac_pkg::mv_type mv);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tdsac_pkg::req_data_type'({mv, code});
      do @(posedge clock); while (!req_tready);
      accumulate_sample(code, mv);
   endtask

   task automatic send_constant_window(input tdsac_pkg::code_type code,
                                       input tdsac_pkg::mv_type mv);
      for (int i = 0; i < WINDOW; i++) send_sample(code, mv);
   endtask

   // A window whose samples scatter around a random center by a random reach, so
   // that the mean codes spread over the whole range instead of piling up at mid-scale.
   task automatic send_random_window();
      int unsigned code_mid, code_reach, mv_mid, mv_reach;
      code_mid   = $urandom_range(0, CODE_TOP);
      code_reach = $urandom_range(0, CODE_TOP) >> $urandom_range(0, CODE_BITS);
      mv_mid     = $urandom_range(0, MV_TOP);
      mv_reach   = $urandom_range(0, MV_TOP) >> $urandom_range(0, MV_BITS);
      for (int i = 0; i < WINDOW; i++) begin
         send_sample(tdsac_pkg::code_type'(pick_near(code_mid, code_reach, CODE_TOP)),
                     tdsac_pkg::mv_type'(pick_near(mv_mid, mv_reach, MV_TOP)));
      end
   endtask

   // Lowers valid, waits for every owed result and then for one conversion time,
   // so that the block is idle before the next register write.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reads a register back and compares it with our copy.
   task automatic check_register(input tdsac_pkg::reg_idx_type idx);
      tdsac_pkg::csr_data_type want;
      want = (idx == tdsac_pkg::REG_REFERENCE) ? tdsac_pkg::csr_data_type'(model_reference)
                                               : tdsac_pkg::csr_data_type'(model_gain);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= tdsac_pkg::csr_addr_type'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch("register readback", 64'(want), 64'(csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge.
   // The read-back follows directly with psel still high.
   task automatic write_register(input tdsac_pkg::reg_idx_type idx,
                                 input tdsac_pkg::csr_data_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= tdsac_pkg::csr_addr_type'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == tdsac_pkg::REG_REFERENCE) model_reference = tdsac_pkg::ref_type'(value);
      else model_gain = tdsac_pkg::gain_type'(value);
      check_register(idx);
   endtask

   task automatic set_conversion(input tdsac_pkg::csr_data_type reference,
                                 input tdsac_pkg::csr_data_type gain);
      write_register(tdsac_pkg::REG_REFERENCE, reference);
      write_register(tdsac_pkg::REG_GAIN, gain);
   endtask

   // Registers come out of reset at 3300 mV and unity gain; one random window
   // is converted with them.
   task automatic test_reset_defaults();
      req_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
      check_register(tdsac_pkg::REG_REFERENCE);
      check_register(tdsac_pkg::REG_GAIN);
      send_random_window();
      drain_results();
   endtask

   // All-zero and all-ones samples, then a window whose means are not whole, so
   // that both averages must truncate.
   task automatic test_field_extremes();
      send_constant_window('0, '0);
      send_constant_window(tdsac_pkg::code_type'(CODE_TOP), tdsac_pkg::mv_type'(MV_TOP));
      for (int i = 0; i < WINDOW; i++) begin
         if (i % 2 == 0) send_sample(tdsac_pkg::code_type'(CODE_TOP),
                                     tdsac_pkg::mv_type'(MV_TOP));
         else send_sample('0, '0);
      end
      drain_results();
   endtask

   // The largest reference with a full-scale code pushes the voltage past Q3.16;
   // a quarter gain keeps the result itself below saturation.
   task automatic test_voltage_clamp();
      set_conversion(MV_TOP, 1024);
      send_constant_window(tdsac_pkg::code_type'(CODE_TOP),
                           tdsac_pkg::mv_type'($urandom_range(0, MV_TOP)));
      drain_results();
   endtask

   // A zero reference gives a zero voltage and a zero result whatever the code.
   task automatic test_zero_reference();
      set_conversion(0, 4096);
      send_constant_window(tdsac_pkg::code_type'(CODE_TOP), tdsac_pkg::mv_type'(MV_TOP));
      drain_results();
   endtask

   // Full gain at a high voltage overruns the output and must saturate with the flag.
   task automatic test_output_saturation();
      set_conversion(5000, 65535);
      send_constant_window(tdsac_pkg::code_type'(CODE_TOP),
                           tdsac_pkg::mv_type'($urandom_range(0, MV_TOP)));
      send_random_window();
      drain_results();
   endtask

   // Zero gain wipes the result out while the averages still come through.
   task automatic test_zero_gain();
      set_conversion(3300, 0);
      send_random_window();
      drain_results();
   endtask

   // The result side holds off for a long stretch while samples keep coming at
   // full rate: the block parks one result, finishes the next window and then
   // has to stop taking samples until the output frees.
   task automatic test_result_backpressure();
      set_conversion(3300, 4096);
      req_gaps_on = 1'b0;
      hold_requests++;
      repeat (3) send_random_window();
      drain_results();
   endtask

   // Several register settings, each with a run of random windows and random
   // idling on either side, switched on and off per window.
   task automatic test_random_settings();
      tdsac_pkg::csr_data_type references[4] = '{1000, 5000, 3300, 8191};
      tdsac_pkg::csr_data_type gains[4]      = '{4096, 65535, 0, 2048};
      for (int s = 0; s < 6; s++) begin
         if (s < 4) set_conversion(references[s], gains[s]);
         else set_conversion($urandom, $urandom);
         for (int w = 0; w < 6; w++) begin
            req_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            send_random_window();
         end
         drain_results();
      end
   endtask

   // The last windows run with neither side idling.
   task automatic test_unthrottled_tail();
      set_conversion($urandom_range(1000, 5000), $urandom_range(0, 65535));
      req_gaps_on    = 1'b0;
      sink_stalls_on = 1'b0;
      repeat (4) send_random_window();
      drain_results();
   endtask

   // Result sink: a long hold-off when one is requested, otherwise random stall
   // bursts while stalling is enabled, otherwise always ready.
   initial begin : result_sink
      int served;
      int gap;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every result transaction is matched against the oldest owed result, field by
   // field. A result that nobody asked for is a failure too.
   always @(posedge clock) begin : result_check
      window_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_windows.size() == 0) begin
            report_mismatch("unexpected result, tds field", 64'd0,
                            64'(rsp_tdata[TDS_LSB +: TDS_BITS]));
         end else begin
            want = pending_windows.pop_front();
            if (rsp_tdata[CODE_BITS-1:0] !== want.code)
               report_mismatch("average_code", 64'(want.code),
                               64'(rsp_tdata[CODE_BITS-1:0]));
            if (rsp_tdata[CODE_BITS +: MV_BITS] !== want.mv)
               report_mismatch("average_millivolts", 64'(want.mv),
                               64'(rsp_tdata[CODE_BITS +: MV_BITS]));
            if (rsp_tdata[TDS_LSB +: TDS_BITS] !== want.tds)
               report_mismatch("dissolved_tenths_ppm", 64'(want.tds),
                               64'(rsp_tdata[TDS_LSB +: TDS_BITS]));
            if (rsp_tuser !== want.sat)
               report_mismatch("saturated", 64'(want.sat), 64'(rsp_tuser));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : test_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_voltage_clamp();
      test_zero_reference();
      test_output_saturation();
      test_zero_gain();
      test_result_backpressure();
      test_random_settings();
      test_unthrottled_tail();
      if (pending_windows.size() != 0) report_mismatch("results never delivered", 64'd0,
                                                       64'(pending_windows.size()));
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
